>>> hw/rtl/cdad_pkg.sv
// Shared types, constants and the month-length table for the calendar date unit.
// Depends on nothing; used by calendar_date_add_and_difference.
package cdad_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F_ERA,
    ST_F_YEAR,
    ST_F_MONTH,
    ST_ADJ,
    ST_B_ERA,
    ST_B_YEAR,
    ST_B_MONTH,
    ST_DONE
  } state_t;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_DIFF = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  localparam int ERA_YEARS  = 400;
  localparam int ERA_DAYS   = 146097;
  localparam int CENT_YEARS = 100;
  localparam int YEAR_DAYS  = 365;
  localparam int MONTHS     = 12;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 23;
  localparam int DIFF_MAX = 4194303;
  localparam int DIFF_MIN = -4194304;

  function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd2:                      r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/calendar_date_add_and_difference.sv
// Gregorian date unit: add a day offset to a date, or take the day difference of two dates.
// Depends on cdad_pkg (state type, codes, calendar constants, month-length table).
//
//   channel   signals                                         flow
//   command   start, busy, kind, year/month/day a and b,      in, beat when start && !busy
//             day_offset
//   result    done, year_out, month_out, day_out,             out, one-cycle strobe
//             day_difference, later, equal, status
//
// One shared adder walks day counts: 400-year eras, then single years, then months.
// Kind 0 walks date A to a day number, adds day_offset and walks the sum back to a date;
// kind 1 walks B, then A, and takes the difference of the two day numbers.
// An invalid date goes straight to done, or runs the year walk when only the day is too big.
// busy is high from the cycle after the accepted beat through the done cycle. rst is sync.
// The receiver cannot stall; results stay until the next accepted beat, done marks them.
module calendar_date_add_and_difference #(
  parameter int MAX_YEAR     = 9999,
  parameter int OFFSET_WIDTH = 21
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic [cdad_pkg::YEAR_W-1:0]       year_a,
  input  logic [cdad_pkg::MONTH_W-1:0]      month_a,
  input  logic [cdad_pkg::DAY_W-1:0]        day_a,
  input  logic [cdad_pkg::YEAR_W-1:0]       year_b,
  input  logic [cdad_pkg::MONTH_W-1:0]      month_b,
  input  logic [cdad_pkg::DAY_W-1:0]        day_b,
  input  logic signed [OFFSET_WIDTH-1:0]    day_offset,
  output logic                              done,
  output logic [cdad_pkg::YEAR_W-1:0]       year_out,
  output logic [cdad_pkg::MONTH_W-1:0]      month_out,
  output logic [cdad_pkg::DAY_W-1:0]        day_out,
  output logic signed [cdad_pkg::DIFF_W-1:0] day_difference,
  output logic                              later,
  output logic                              equal,
  output logic [1:0]                        status
);

  localparam int MAX_LEAP = ((MAX_YEAR % 400 == 0) ||
                             ((MAX_YEAR % 4 == 0) && (MAX_YEAR % 100 != 0))) ? 1 : 0;
  // last valid day number, counted from day 0 = 0000-01-01
  localparam int HI = 365 * MAX_YEAR + (MAX_YEAR + 3) / 4 - (MAX_YEAR + 99) / 100
                      + (MAX_YEAR + 399) / 400 + 364 + MAX_LEAP;
  localparam int NW = $clog2(HI + 1);
  localparam int SW = ((NW > OFFSET_WIDTH) ? NW : OFFSET_WIDTH) + 2;
  localparam int DW = (SW > cdad_pkg::DIFF_W + 1) ? SW : cdad_pkg::DIFF_W + 1;
  localparam int YN = $clog2(MAX_YEAR + 1);
  localparam int YW = (YN > cdad_pkg::YEAR_W) ? YN : cdad_pkg::YEAR_W;

  localparam logic signed [DW-1:0] DMAX = DW'(cdad_pkg::DIFF_MAX);
  localparam logic signed [DW-1:0] DMIN = DW'(cdad_pkg::DIFF_MIN);

  cdad_pkg::state_t state, state_next;

  logic                                kind_r;
  logic [cdad_pkg::YEAR_W-1:0]         ya_r;
  logic [cdad_pkg::MONTH_W-1:0]        ma_r;
  logic [cdad_pkg::DAY_W-1:0]          da_r;
  logic signed [OFFSET_WIDTH-1:0]      off_r;
  logic [YW-1:0]                       ycnt;
  logic [cdad_pkg::MONTH_W-1:0]        wm;
  logic [cdad_pkg::DAY_W-1:0]          wd;
  logic [cdad_pkg::MONTH_W-1:0]        mcnt;
  logic [6:0]                          e100;
  logic [1:0]                          ecent;
  logic                                a_phase;
  logic signed [SW-1:0]                acc;
  logic [NW-1:0]                       nsave;

  logic                                accept;
  logic                                a_ok, b_ok, basic_ok;
  logic                                leap;
  logic [cdad_pkg::MONTH_W-1:0]        tbl_month;
  logic [cdad_pkg::DAY_W-1:0]          mdays;
  logic signed [SW-1:0]                addend, sum;
  logic                                neg;
  logic                                era_more;
  logic                                day_bad;
  logic                                range_bad;
  logic signed [DW-1:0]                dx;
  logic [6:0]                          e100_inc;
  logic [1:0]                          ecent_inc;

  assign busy   = (state != cdad_pkg::ST_IDLE);
  assign done   = (state == cdad_pkg::ST_DONE);
  assign accept = start && !busy;

  assign a_ok = (YW'(year_a) <= YW'(MAX_YEAR)) && (month_a != '0) &&
                (month_a <= 4'(cdad_pkg::MONTHS)) && (day_a != '0);
  assign b_ok = (YW'(year_b) <= YW'(MAX_YEAR)) && (month_b != '0) &&
                (month_b <= 4'(cdad_pkg::MONTHS)) && (day_b != '0);
  assign basic_ok = a_ok && ((kind == cdad_pkg::KIND_ADD) || b_ok);

  // era year = ecent*100 + e100; 100 is a multiple of 4 so e100 gives year mod 4
  assign leap = (e100[1:0] == 2'd0) && ((e100 != '0) || (ecent == '0));
  assign tbl_month = (state == cdad_pkg::ST_F_YEAR) ? wm : mcnt;
  assign mdays     = cdad_pkg::month_days(tbl_month, leap);

  assign era_more  = (ycnt >= YW'(cdad_pkg::ERA_YEARS));
  assign day_bad   = (wd > mdays);
  assign e100_inc  = (e100 == 7'(cdad_pkg::CENT_YEARS - 1)) ? 7'd0 : e100 + 7'd1;
  assign ecent_inc = (e100 == 7'(cdad_pkg::CENT_YEARS - 1)) ? ecent + 2'd1 : ecent;

  // shared adder
  always_comb begin
    unique case (state)
      cdad_pkg::ST_F_ERA:   addend = SW'(cdad_pkg::ERA_DAYS);
      cdad_pkg::ST_F_YEAR:  addend = SW'(cdad_pkg::YEAR_DAYS) + SW'({1'b0, leap});
      cdad_pkg::ST_F_MONTH: addend = SW'({1'b0, mdays});
      cdad_pkg::ST_ADJ:     addend = (kind_r == cdad_pkg::KIND_ADD) ? SW'(off_r) :
                                     -$signed({{(SW-NW){1'b0}}, nsave});
      cdad_pkg::ST_B_ERA:   addend = -SW'(cdad_pkg::ERA_DAYS);
      cdad_pkg::ST_B_YEAR:  addend = -(SW'(cdad_pkg::YEAR_DAYS) + SW'({1'b0, leap}));
      cdad_pkg::ST_B_MONTH: addend = -SW'({1'b0, mdays});
      default:              addend = '0;
    endcase
  end

  assign sum       = acc + addend;
  assign neg       = sum[SW-1];
  assign range_bad = neg || (sum > SW'(HI));
  assign dx        = DW'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cdad_pkg::ST_IDLE: begin
        if (start) state_next = basic_ok ? cdad_pkg::ST_F_ERA : cdad_pkg::ST_DONE;
      end
      cdad_pkg::ST_F_ERA: begin
        if (!era_more) state_next = cdad_pkg::ST_F_YEAR;
      end
      cdad_pkg::ST_F_YEAR: begin
        if (ycnt == '0) state_next = day_bad ? cdad_pkg::ST_DONE : cdad_pkg::ST_F_MONTH;
      end
      cdad_pkg::ST_F_MONTH: begin
        if (mcnt == wm) state_next = a_phase ? cdad_pkg::ST_ADJ : cdad_pkg::ST_F_ERA;
      end
      cdad_pkg::ST_ADJ: begin
        if ((kind_r == cdad_pkg::KIND_ADD) && !range_bad) state_next = cdad_pkg::ST_B_ERA;
        else state_next = cdad_pkg::ST_DONE;
      end
      cdad_pkg::ST_B_ERA: begin
        if (neg) state_next = cdad_pkg::ST_B_YEAR;
      end
      cdad_pkg::ST_B_YEAR: begin
        if (neg) state_next = cdad_pkg::ST_B_MONTH;
      end
      cdad_pkg::ST_B_MONTH: begin
        if (neg) state_next = cdad_pkg::ST_DONE;
      end
      cdad_pkg::ST_DONE: begin
        state_next = cdad_pkg::ST_IDLE;
      end
      default: state_next = cdad_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      cdad_pkg::ST_IDLE: begin
        if (accept) begin
          kind_r         <= kind;
          ya_r           <= year_a;
          ma_r           <= month_a;
          da_r           <= day_a;
          off_r          <= day_offset;
          year_out       <= '0;
          month_out      <= '0;
          day_out        <= '0;
          day_difference <= '0;
          later          <= 1'b0;
          equal          <= 1'b0;
          status         <= basic_ok ? cdad_pkg::STATUS_OK : cdad_pkg::STATUS_BAD_DATE;
          e100           <= '0;
          ecent          <= '0;
          // kind 1 walks B first so the final add gives A minus B
          if (kind == cdad_pkg::KIND_DIFF) begin
            ycnt    <= YW'(year_b);
            wm      <= month_b;
            wd      <= day_b;
            acc     <= SW'(day_b - 5'd1);
            a_phase <= 1'b0;
          end else begin
            ycnt    <= YW'(year_a);
            wm      <= month_a;
            wd      <= day_a;
            acc     <= SW'(day_a - 5'd1);
            a_phase <= 1'b1;
          end
        end
      end
      cdad_pkg::ST_F_ERA: begin
        if (era_more) begin
          acc  <= sum;
          ycnt <= ycnt - YW'(cdad_pkg::ERA_YEARS);
        end
      end
      cdad_pkg::ST_F_YEAR: begin
        if (ycnt != '0) begin
          acc   <= sum;
          ycnt  <= ycnt - YW'(1);
          e100  <= e100_inc;
          ecent <= ecent_inc;
        end else begin
          mcnt <= 4'd1;
          if (day_bad) status <= cdad_pkg::STATUS_BAD_DATE;
        end
      end
      cdad_pkg::ST_F_MONTH: begin
        if (mcnt != wm) begin
          acc  <= sum;
          mcnt <= mcnt + 4'd1;
        end else if (!a_phase) begin
          nsave   <= acc[NW-1:0];
          ycnt    <= YW'(ya_r);
          wm      <= ma_r;
          wd      <= da_r;
          acc     <= SW'(da_r - 5'd1);
          a_phase <= 1'b1;
          e100    <= '0;
          ecent   <= '0;
        end
      end
      cdad_pkg::ST_ADJ: begin
        if (kind_r == cdad_pkg::KIND_ADD) begin
          if (range_bad) begin
            status <= cdad_pkg::STATUS_RANGE;
          end else begin
            acc   <= sum;
            ycnt  <= '0;
            e100  <= '0;
            ecent <= '0;
          end
        end else begin
          later <= !neg && (sum != '0);
          equal <= (sum == '0);
          if (dx > DMAX)      day_difference <= DMAX[cdad_pkg::DIFF_W-1:0];
          else if (dx < DMIN) day_difference <= DMIN[cdad_pkg::DIFF_W-1:0];
          else                day_difference <= dx[cdad_pkg::DIFF_W-1:0];
        end
      end
      cdad_pkg::ST_B_ERA: begin
        if (!neg) begin
          acc  <= sum;
          ycnt <= ycnt + YW'(cdad_pkg::ERA_YEARS);
        end
      end
      cdad_pkg::ST_B_YEAR: begin
        if (!neg) begin
          acc   <= sum;
          ycnt  <= ycnt + YW'(1);
          e100  <= e100_inc;
          ecent <= ecent_inc;
        end else begin
          mcnt <= 4'd1;
        end
      end
      cdad_pkg::ST_B_MONTH: begin
        if (!neg) begin
          acc  <= sum;
          mcnt <= mcnt + 4'd1;
        end else begin
          year_out  <= ycnt[cdad_pkg::YEAR_W-1:0];
          month_out <= mcnt;
          day_out   <= acc[cdad_pkg::DAY_W-1:0] + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // the unit only goes idle through a result beat
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_shift_date: assert property (@(posedge clk) disable iff (rst)
    (done && (status == cdad_pkg::STATUS_OK) && (kind_r == cdad_pkg::KIND_ADD)) |->
    ((month_out != '0) && (month_out <= 4'(cdad_pkg::MONTHS)) && (day_out != '0)))
    else $error("shifted date out of calendar range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != cdad_pkg::STATUS_OK)) |->
    ((day_difference == '0) && !later && !equal && (month_out == '0)))
    else $error("error result carries data");

endmodule
